// ----- design/class_score_smoothing_argmax_macros.svh -----
// Assertion macros shared by the design files.
// Every check is clocked on clk and is off while arst_n is low.
`ifndef CLASS_SCORE_SMOOTHING_ARGMAX_MACROS_SVH
`define CLASS_SCORE_SMOOTHING_ARGMAX_MACROS_SVH

// The expression holds at every clock edge.
`define CSSA_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("check failed: invariant");

// When the antecedent holds, the consequent holds in the same cycle.
`define CSSA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define CSSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

// ----- design/cssa_pkg.sv -----
package cssa_pkg;

	localparam int NUM_CLASSES = 8;
	localparam int SCORE_W = 16;
	localparam int CLS_W = 3;
	localparam int LEAF_N = 8;
	localparam int ACC_W = 31;
	localparam int FRAC_W = 15;
	localparam int IN_W = 128;
	localparam int OUT_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [SCORE_W-1:0] Q_ONE = 16'h8000;
	localparam logic [SCORE_W-1:0] ALPHA_RST = 16'd16384;
	localparam logic [SCORE_W-1:0] THRESH_RST = 16'd9830;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA = 1'b0,
		CFG_THRESHOLD = 1'b1
	} cfg_idx_t;

	// One arg-max candidate: a class index and its smoothed score.
	typedef struct packed {
		logic used;
		logic [CLS_W-1:0] idx;
		logic [SCORE_W-1:0] val;
	} cand_t;

	// Load strobes for the merge pipeline stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} cssa_ld_t;

	// Values above 1.0 in Q1.15 saturate to 1.0.
	function automatic logic [SCORE_W-1:0] clamp_one(input logic [SCORE_W-1:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

	// The left candidate has the lower indices, so it wins a tie.
	function automatic cand_t pick(input cand_t l, input cand_t r);
		return (r.used && (!l.used || (r.val > l.val))) ? r : l;
	endfunction

endpackage

// ----- design/cssa_lane.sv -----
module cssa_lane
	import cssa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [SCORE_W-1:0] score,
	input  logic [SCORE_W-1:0] alpha,
	input  logic [SCORE_W-1:0] keep,
	output logic [SCORE_W-1:0] smoothed
);

	logic [SCORE_W-1:0] smoothed_q;
	logic [SCORE_W-1:0] score_sat;
	logic [ACC_W-1:0]   acc;

	assign score_sat = clamp_one(score);

	// Both products are summed at full width and truncated once.
	assign acc = ACC_W'(keep) * ACC_W'(smoothed_q) + ACC_W'(alpha) * ACC_W'(score_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (load) begin
			smoothed_q <= acc[FRAC_W +: SCORE_W];
		end
	end

	assign smoothed = smoothed_q;

endmodule

// ----- design/cssa_merge.sv -----
module cssa_merge
	import cssa_pkg::*;
(
	input  logic               clk,
	input  cssa_ld_t           ld,
	input  logic [SCORE_W-1:0] smoothed [NUM_CLASSES],
	input  logic [SCORE_W-1:0] threshold,
	output logic [CLS_W-1:0]   cls,
	output logic [SCORE_W-1:0] top,
	output logic               above
);

	cand_t leaf [LEAF_N];
	cand_t lvl1 [LEAF_N/2];
	cand_t lvl2 [LEAF_N/4];
	cand_t cand_s2 [LEAF_N/4];
	cand_t fin;
	logic  fin_above;
	logic [CLS_W-1:0]   cls_s3;
	logic [SCORE_W-1:0] top_s3;
	logic               above_s3;

	for (genvar i = 0; i < LEAF_N; i++) begin : g_leaf
		if (i < NUM_CLASSES) begin : g_used
			assign leaf[i] = '{used: 1'b1, idx: CLS_W'(i), val: smoothed[i]};
		end else begin : g_unused
			assign leaf[i] = '0;
		end
	end

	for (genvar j = 0; j < LEAF_N/2; j++) begin : g_lvl1
		assign lvl1[j] = pick(leaf[2*j], leaf[2*j+1]);
	end

	for (genvar k = 0; k < LEAF_N/4; k++) begin : g_lvl2
		assign lvl2[k] = pick(lvl1[2*k], lvl1[2*k+1]);
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			cand_s2 <= lvl2;
		end
	end

	assign fin = pick(cand_s2[0], cand_s2[1]);
	assign fin_above = fin.val > threshold;

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			cls_s3   <= fin_above ? fin.idx : '0;
			top_s3   <= fin.val;
			above_s3 <= fin_above;
		end
	end

	assign cls = cls_s3;
	assign top = top_s3;
	assign above = above_s3;

endmodule

// ----- design/class_score_smoothing_argmax.sv -----
// Pipeline: a result passes the lane register, the register after the first two arg-max
// tree levels, then the output register after the final compare; a stall holds each one.
// Throughput: one score vector per cycle unless the master side holds off the output.
// Reset: arst_n clears the smoothed scores to zero, all stage valids, and loads
// smoothing_alpha = 16384 and decision_threshold = 9830.
`include "class_score_smoothing_argmax_macros.svh"

module class_score_smoothing_argmax
	import cssa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Fields from bit 0 up: score_0 .. score_7, 16 bits each.
	input  logic [IN_W-1:0]      s_axis_tdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0 up: predicted_class (3), top_smoothed_score (16),
	// above_threshold (1), then four zero bits.
	output logic [OUT_W-1:0]     m_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_wdata
);

	// Configuration. The alpha register stores the value already saturated to
	// 1.0, and its complement (the weight of the old average) is kept beside it
	// so that the lanes see both without any arithmetic in front of the multipliers.
	logic [SCORE_W-1:0] alpha_q;
	logic [SCORE_W-1:0] keep_q;
	logic [SCORE_W-1:0] thresh_q;
	logic [SCORE_W-1:0] alpha_sat;

	assign alpha_sat = clamp_one(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RST;
			keep_q   <= Q_ONE - ALPHA_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALPHA: begin
					alpha_q <= alpha_sat;
					keep_q  <= Q_ONE - alpha_sat;
				end
				CFG_THRESHOLD: begin
					thresh_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. Every stage has its own valid bit and moves forward
	// whenever it is empty or the stage after it moves, so a new transaction is
	// taken even while a finished result waits at the output register.
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic en1;
	logic en2;
	logic en3;
	logic in_load;
	cssa_ld_t ld;

	assign en3 = !v3_q || m_axis_tready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign s_axis_tready = en1;
	assign in_load = en1 && s_axis_tvalid;
	assign ld = '{ld_s2: en2, ld_s3: en3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_axis_tvalid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// One lane per class. The lane register is both the running average and the
	// first pipeline stage: it only changes when a transaction is accepted, and
	// acceptance is held off while that stage is full and cannot move on.
	logic [SCORE_W-1:0] smoothed [NUM_CLASSES];

	for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_lane
		cssa_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (in_load),
			.score    (s_axis_tdata[i*SCORE_W +: SCORE_W]),
			.alpha    (alpha_q),
			.keep     (keep_q),
			.smoothed (smoothed[i])
		);
	end

	// Merge: a registered arg-max tree with the lower index preferred on ties,
	// followed by the threshold decision in the output register.
	logic [CLS_W-1:0]   pred_cls;
	logic [SCORE_W-1:0] top_score;
	logic               above;

	cssa_merge u_merge (
		.clk       (clk),
		.ld        (ld),
		.smoothed  (smoothed),
		.threshold (thresh_q),
		.cls       (pred_cls),
		.top       (top_score),
		.above     (above)
	);

	assign m_axis_tvalid = v3_q;
	assign m_axis_tdata = {(OUT_W - CLS_W - SCORE_W - 1)'(0), above, top_score, pred_cls};

	// A maximum that is not above the threshold is always reported as class zero.
	`CSSA_ASSERT_SAME(a_cls_forced, m_axis_tvalid && !above, pred_cls == '0)
	// Saturated inputs keep every reported maximum within 1.0.
	`CSSA_ASSERT_SAME(a_top_range, m_axis_tvalid, top_score <= Q_ONE)
	// The averages move only on an accepted transaction.
	`CSSA_ASSERT_NEXT(a_state_hold, !in_load, $stable(smoothed[0]) && $stable(smoothed[NUM_CLASSES-1]))
	// A full first stage that cannot drain must block the input side.
	`CSSA_ASSERT_SAME(a_no_overrun, v1_q && !en2, !s_axis_tready)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import cssa_pkg::*;

	// One score vector as it travels on the slave side: class 0 in the lowest bits.
	typedef logic [NUM_CLASSES-1:0][SCORE_W-1:0] score_vec_t;

	// One decision as it travels on the master side, from the lowest bit up:
	// predicted class, top smoothed score, above-threshold flag.
	typedef struct packed {
		logic               above;
		logic [SCORE_W-1:0] top;
		logic [CLS_W-1:0]   cls;
	} decision_t;

	// One row of the directed table. The settings are written before the item,
	// and a typed decision replaces the prediction where the row carries one.
	typedef struct {
		logic               wr_alpha;
		logic [SCORE_W-1:0] alpha;
		logic               wr_thr;
		logic [SCORE_W-1:0] thr;
		score_vec_t         scores;
		logic               typed;
		decision_t          decision;
	} stim_row_t;

	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 225;
	// The output holds off once for this many cycles after this many decisions.
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER = 500;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ALPHA;
	logic [SCORE_W-1:0]   cfg_wdata = '0;

	class_score_smoothing_argmax dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// Our own copy of the smoothing state and of both registers.
	logic [SCORE_W-1:0] ema_shadow [NUM_CLASSES];
	logic [SCORE_W-1:0] alpha_shadow = ALPHA_RST;
	logic [SCORE_W-1:0] thr_shadow = THRESH_RST;

	// Decisions that are owed by the block, oldest first.
	decision_t pending_decisions [$];
	stim_row_t directed_rows [$];

	int  mismatch_count = 0;
	int  decisions_seen = 0;
	// While quiet is set neither side draws random idle gaps.
	bit  quiet = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs on either handshake.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Advance the shadow state by one score vector and work out the decision.
	// Each lane blends the old value and the saturated new score with weights
	// that sum to one, and the sum is truncated once. The arg-max keeps the
	// first class on a tie because only a strictly larger value replaces it.
	function automatic decision_t smooth_and_pick(input score_vec_t scores);
		logic [SCORE_W-1:0] weight_new;
		logic [SCORE_W-1:0] weight_old;
		logic [SCORE_W-1:0] sat_score;
		logic [SCORE_W-1:0] blended;
		logic [SCORE_W-1:0] best;
		logic [CLS_W-1:0]   best_cls;
		logic [31:0]        acc;
		decision_t          d;
		weight_new = (alpha_shadow > Q_ONE) ? Q_ONE : alpha_shadow;
		weight_old = Q_ONE - weight_new;
		best = '0;
		best_cls = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			sat_score = (scores[i] > Q_ONE) ? Q_ONE : scores[i];
			acc = 32'(weight_old) * 32'(ema_shadow[i]) + 32'(weight_new) * 32'(sat_score);
			blended = acc[30:15];
			ema_shadow[i] = blended;
			if (i == 0 || blended > best) begin
				best = blended;
				best_cls = CLS_W'(i);
			end
		end
		d.above = (best > thr_shadow);
		d.top = best;
		d.cls = d.above ? best_cls : '0;
		return d;
	endfunction

	// All classes at one level, with a single class set apart.
	function automatic score_vec_t vec_with(input logic [SCORE_W-1:0] base, input int cls,
			input logic [SCORE_W-1:0] val);
		score_vec_t v;
		for (int i = 0; i < NUM_CLASSES; i++)
			v[i] = base;
		v[cls] = val;
		return v;
	endfunction

	function automatic void add_row(input logic wr_a, input logic [SCORE_W-1:0] a,
			input logic wr_t, input logic [SCORE_W-1:0] t, input score_vec_t scores,
			input logic typed, input logic [CLS_W-1:0] cls, input logic [SCORE_W-1:0] top,
			input logic above);
		stim_row_t r;
		r.wr_alpha = wr_a;
		r.alpha = a;
		r.wr_thr = wr_t;
		r.thr = t;
		r.scores = scores;
		r.typed = typed;
		r.decision.cls = cls;
		r.decision.top = top;
		r.decision.above = above;
		directed_rows.push_back(r);
	endfunction

	// Random score vectors. Most look like a classifier output with one clear
	// winner, some carry a tie for the top, some use the full 16-bit range so
	// that every bit toggles and saturation is hit, and some are flat.
	function automatic score_vec_t draw_scores();
		score_vec_t v;
		int unsigned kind;
		int unsigned lead;
		int unsigned peak;
		kind = $urandom_range(0, 99);
		lead = $urandom_range(0, NUM_CLASSES - 1);
		peak = $urandom_range(8192, 32768);
		if (kind < 78) begin
			for (int i = 0; i < NUM_CLASSES; i++)
				v[i] = SCORE_W'($urandom_range(0, 32768 - peak));
			v[lead] = SCORE_W'(peak);
			if (kind >= 65)
				v[$urandom_range(0, NUM_CLASSES - 1)] = SCORE_W'(peak);
		end else if (kind < 90) begin
			for (int i = 0; i < NUM_CLASSES; i++)
				v[i] = SCORE_W'($urandom_range(0, 65535));
		end else begin
			v = vec_with(SCORE_W'($urandom_range(0, 32768)), 0, SCORE_W'(0));
			v[0] = v[1];
		end
		return v;
	endfunction

	function automatic logic [SCORE_W-1:0] draw_alpha();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return Q_ONE;
			2: return 16'hFFFF;
			3: return SCORE_W'($urandom_range(1, 2048));
			4: return SCORE_W'($urandom_range(0, 32768));
			default: return SCORE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [SCORE_W-1:0] draw_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return Q_ONE;
			2: return 16'hFFFF;
			default: return SCORE_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// Offer one score vector and wait for its transaction. The decision is
	// queued at the accepting edge, then the sender may idle for a while.
	// Valid stays high when no gap follows, so the next item goes out
	// back to back.
	task automatic send_scores(input score_vec_t scores, input logic typed,
			input decision_t typed_decision);
		decision_t d;
		int unsigned gap;
		s_axis_tdata <= scores;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		d = smooth_and_pick(scores);
		pending_decisions.push_back(typed ? typed_decision : d);
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed decision, plus the pipeline depth
	// and some margin, so that register writes land on an idle block.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_decisions.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write the requested registers on consecutive edges. The write enable
	// is lowered only once, after the last write.
	task automatic apply_settings(input logic wr_a, input logic [SCORE_W-1:0] a,
			input logic wr_t, input logic [SCORE_W-1:0] t);
		if (wr_a) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_ALPHA;
			cfg_wdata <= a;
			@(posedge clk);
			alpha_shadow = a;
		end
		if (wr_t) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_THRESHOLD;
			cfg_wdata <= t;
			@(posedge clk);
			thr_shadow = t;
		end
		if (wr_a || wr_t) begin
			cfg_we <= 1'b0;
		end
	endtask

	// Compare one decision from the master side with the oldest one owed.
	function automatic void check_decision(input logic [OUT_W-1:0] word);
		decision_t got;
		decision_t want;
		logic [OUT_W-$bits(decision_t)-1:0] pad;
		got = word[$bits(decision_t)-1:0];
		pad = word[OUT_W-1:$bits(decision_t)];
		if (pending_decisions.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected decision: class %0d top %0d above %0d",
					got.cls, got.top, got.above);
			return;
		end
		want = pending_decisions.pop_front();
		if (got.cls !== want.cls || got.top !== want.top || got.above !== want.above
				|| pad !== '0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("decision %0d mismatch: expected class %0d top %0d above %0d,",
					decisions_seen, want.cls, want.top, want.above,
					" got class %0d top %0d above %0d pad %0h",
					got.cls, got.top, got.above, pad);
		end
	endfunction

	// Master side. Decisions are checked at the edge that completes their
	// transaction; ready is then redrawn for the next cycle. Once, after a
	// few hundred decisions, the output holds off long enough for the block
	// to fill up and push back on its input.
	initial begin
		int unsigned stall_left;
		bit held_off;
		stall_left = 0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
				check_decision(m_axis_tdata);
				decisions_seen++;
			end
			if (!held_off && decisions_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				stall_left = HOLD_OFF_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = draw_gap();
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Main sequence: reset, the directed table, then random phases with
	// fresh settings each, and the final verdict.
	initial begin
		stim_row_t r;
		decision_t no_decision;
		no_decision = '0;
		for (int i = 0; i < NUM_CLASSES; i++)
			ema_shadow[i] = '0;

		// The directed table. Where the decision is typed in, it follows
		// directly from the settings and from the state left by earlier rows.
		// Right after reset everything is zero and nothing is above threshold.
		add_row(0, 0, 0, 0, '0, 1, 0, 0, 0);
		// Full weight on the new scores, all inputs above one: they saturate,
		// all classes tie at one and the lowest index wins.
		add_row(1, Q_ONE, 0, 0, vec_with(16'hFFFF, 0, 16'hFFFF), 1, 0, 16'h8000, 1);
		add_row(0, 0, 0, 0, vec_with(16'd100, 5, 16'd20000), 1, 5, 16'd20000, 1);
		// Alpha above one behaves as exactly one.
		add_row(1, 16'hFFFF, 0, 0, vec_with(16'd0, 7, 16'h8000), 1, 7, 16'h8000, 1);
		// A threshold at or above one can never be exceeded.
		add_row(0, 0, 1, 16'hFFFF, vec_with(16'd0, 7, 16'h8000), 1, 0, 16'h8000, 0);
		add_row(0, 0, 1, Q_ONE, vec_with(16'd0, 3, 16'h8000), 1, 0, 16'h8000, 0);
		// A zero threshold is not exceeded by a zero maximum.
		add_row(0, 0, 1, 16'd0, '0, 1, 0, 0, 0);
		add_row(0, 0, 0, 0, vec_with(16'd0, 2, 16'd1), 1, 2, 16'd1, 1);
		// Zero alpha freezes the smoothed scores, even for saturating inputs.
		add_row(1, 16'd0, 0, 0, vec_with(16'h8000, 0, 16'h1234), 1, 2, 16'd1, 1);
		add_row(0, 0, 0, 0, vec_with(16'hFFFF, 0, 16'hFFFF), 1, 2, 16'd1, 1);
		// A maximum equal to the threshold is not above it; one more is.
		add_row(1, Q_ONE, 1, 16'd12345, vec_with(16'd0, 1, 16'd12345), 1, 0, 16'd12345, 0);
		add_row(0, 0, 0, 0, vec_with(16'd0, 1, 16'd12346), 1, 1, 16'd12346, 1);
		add_row(0, 0, 0, 0, vec_with(16'h7FFF, 0, 16'h7FFF), 1, 0, 16'h7FFF, 1);
		// A score just above one saturates and ties with the others.
		add_row(0, 0, 0, 0, vec_with(16'h8000, 6, 16'h8001), 1, 0, 16'h8000, 1);
		// From here on the predictor supplies the decisions.
		add_row(1, ALPHA_RST, 1, THRESH_RST, vec_with(16'd0, 4, 16'd30000), 0, 0, 0, 0);
		add_row(0, 0, 0, 0, vec_with(16'd0, 6, 16'd30000), 0, 0, 0, 0);
		add_row(1, 16'd1, 0, 0, vec_with(16'h8000, 0, 16'h8000), 0, 0, 0, 0);
		add_row(1, 16'd32767, 0, 0, vec_with(16'd0, 0, 16'hFFFF), 0, 0, 0, 0);
		add_row(0, 0, 0, 0, vec_with(16'h5555, 3, 16'hAAAA), 0, 0, 0, 0);
		add_row(0, 0, 0, 0, vec_with(16'hAAAA, 2, 16'h5555), 0, 0, 0, 0);
		add_row(0, 0, 1, 16'h7FFF, vec_with(16'h8000, 0, 16'h8000), 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			r = directed_rows[k];
			if (r.wr_alpha || r.wr_thr) begin
				wait_idle();
				apply_settings(r.wr_alpha, r.alpha, r.wr_thr, r.thr);
			end
			send_scores(r.scores, r.typed, r.decision);
		end

		// Random phases. One phase runs with no idling at all; it is also
		// where the long output hold-off falls, so the input stalls back to back.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			apply_settings(1'b1, draw_alpha(), 1'b1, draw_threshold());
			quiet = (phase == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_scores(draw_scores(), 1'b0, no_decision);
		end
		quiet = 1'b0;

		// Let everything owed arrive, then watch for stray output for a while.
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_decisions.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
